// File: src/gms_pkg.sv
// Shared types, codes and helper functions of the gimbal mode supervisor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gms_pkg;

  // Default sizes of the link age counters and of the stored targets.
  localparam int GmsAgeWidth    = 16;
  localparam int GmsTargetWidth = 32;

  // Width of the watchdog timeout register and its value after reset.
  localparam int              TimeoutWidth = 16;
  localparam logic [15:0]     TimeoutReset = 16'd25;

  // Stream tdata widths, padded to whole bytes, and the tuser width.
  localparam int InDataWidth  = 120;
  localparam int InUserWidth  = 2;
  localparam int OutDataWidth = 80;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_STATUS = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // Operator mode codes.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SYNC   = 2'd1;
  localparam logic [1:0] MODE_JOG    = 2'd2;
  localparam logic [1:0] MODE_FOLLOW = 2'd3;

  // Reported supervisor state codes.
  localparam logic [2:0] SUP_STOP   = 3'd0;
  localparam logic [2:0] SUP_READY  = 3'd1;
  localparam logic [2:0] SUP_SYNC   = 3'd2;
  localparam logic [2:0] SUP_JOG    = 3'd3;
  localparam logic [2:0] SUP_FOLLOW = 3'd4;
  localparam logic [2:0] SUP_ERROR  = 3'd5;

  // Supervisor state register, one-hot.
  typedef enum logic [5:0] {
    ST_STOP   = 6'b000001,
    ST_READY  = 6'b000010,
    ST_SYNC   = 6'b000100,
    ST_JOG    = 6'b001000,
    ST_FOLLOW = 6'b010000,
    ST_ERROR  = 6'b100000
  } sup_state_e;

  // One input item as held in the input register.
  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         requested_mode_code;
    logic               reset_request;
    logic signed [31:0] target_pitch_in;
    logic signed [31:0] target_yaw_in;
    logic signed [15:0] pitch_speed_in;
    logic signed [15:0] yaw_speed_in;
    logic [15:0]        plc_error_code;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         cmd_mode;
    logic               cmd_exec;
    logic               cmd_ack;
    logic [3:0]         jog_dirs;
    logic               jog_override_full;
    logic signed [31:0] cmd_target_pitch;
    logic signed [31:0] cmd_target_yaw;
    logic [2:0]         supervisor_state;
    logic               operator_online;
    logic               controller_online;
    logic               fault_active;
  } result_t;

  function automatic logic [2:0] state_code(input sup_state_e s);
    logic [2:0] c;
    unique case (s)
      ST_STOP:   c = SUP_STOP;
      ST_READY:  c = SUP_READY;
      ST_SYNC:   c = SUP_SYNC;
      ST_JOG:    c = SUP_JOG;
      ST_FOLLOW: c = SUP_FOLLOW;
      ST_ERROR:  c = SUP_ERROR;
      default:   c = SUP_STOP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/gms_in_stage.sv
// Input register of the gimbal mode supervisor: holds one accepted item.
// Depends on gms_pkg.
`default_nettype none

module gms_in_stage
  import gms_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire logic     out_free_i,
  output logic          fire_o,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // A tick needs a free result slot; other items finish without one.
  assign fire_o     = valid_q && ((item_q.opcode != OP_TICK) || out_free_i);
  assign in_ready_o = !valid_q || fire_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

// File: src/gms_core.sv
// Supervisor core: held link data, watchdog ages, timeout register and the
// state decision for one item. Depends on gms_pkg.
`default_nettype none

module gms_core
  import gms_pkg::*;
#(
  parameter int AGE_WIDTH    = GmsAgeWidth,
  parameter int TARGET_WIDTH = GmsTargetWidth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              fire_i,
  input  wire in_item_t          item_i,
  output logic                   tick_o,
  output result_t                result_o
);

  localparam int CmpW = (AGE_WIDTH > TimeoutWidth) ? AGE_WIDTH : TimeoutWidth;

  logic [TimeoutWidth-1:0]       timeout_q;
  logic [2:0]                    mode_code_q;
  logic                          reset_req_q;
  logic signed [TARGET_WIDTH-1:0] tp_q, tp_d;
  logic signed [TARGET_WIDTH-1:0] ty_q, ty_d;
  logic [15:0]                   ps_q, ys_q;
  logic                          fault_q;
  logic [AGE_WIDTH-1:0]          op_age_q, op_age_d;
  logic [AGE_WIDTH-1:0]          plc_age_q, plc_age_d;
  sup_state_e                    state_q, state_d;
  logic                          prev_reset_q;

  logic       op_alive, ctrl_alive;
  logic [1:0] desired;
  logic       ack;

  function automatic logic signed [TARGET_WIDTH-1:0] sat_target(input logic [31:0] v);
    logic fits;
    logic signed [TARGET_WIDTH-1:0] r;
    fits = (v[31:TARGET_WIDTH-1] == {(33 - TARGET_WIDTH){v[31]}});
    if (fits) begin
      r = v[TARGET_WIDTH-1:0];
    end else if (v[31]) begin
      r = {1'b1, {(TARGET_WIDTH - 1){1'b0}}};
    end else begin
      r = {1'b0, {(TARGET_WIDTH - 1){1'b1}}};
    end
    return r;
  endfunction

  assign tp_d = sat_target(item_i.target_pitch_in);
  assign ty_d = sat_target(item_i.target_yaw_in);

  assign tick_o     = fire_i && (item_i.opcode == OP_TICK);
  assign op_alive   = CmpW'(op_age_q) < CmpW'(timeout_q);
  assign ctrl_alive = CmpW'(plc_age_q) < CmpW'(timeout_q);

  always_comb begin
    desired = MODE_IDLE;
    if (op_alive && (mode_code_q == {1'b0, MODE_SYNC} || mode_code_q == {1'b0, MODE_JOG} ||
                     mode_code_q == {1'b0, MODE_FOLLOW})) begin
      desired = mode_code_q[1:0];
    end
  end

  // State decision; the order of the checks is the priority.
  always_comb begin
    state_d = ST_READY;
    ack     = 1'b0;
    priority if (!ctrl_alive) begin
      state_d = ST_READY;
    end else if (fault_q) begin
      if (op_alive && reset_req_q && !prev_reset_q) begin
        ack     = 1'b1;
        state_d = ST_READY;
      end else begin
        state_d = ST_ERROR;
      end
    end else if (!op_alive) begin
      state_d = ST_READY;
    end else if (desired == MODE_SYNC) begin
      state_d = ST_SYNC;
    end else if (desired == MODE_JOG) begin
      state_d = ST_JOG;
    end else if (desired == MODE_FOLLOW) begin
      state_d = ST_FOLLOW;
    end else begin
      state_d = ST_READY;
    end
  end

  always_comb begin
    result_o                   = '0;
    result_o.cmd_mode          = (state_d == ST_ERROR) ? MODE_IDLE : desired;
    result_o.cmd_ack           = ack;
    result_o.supervisor_state  = state_code(state_d);
    result_o.operator_online   = op_alive;
    result_o.controller_online = ctrl_alive;
    result_o.fault_active      = fault_q;
    unique case (state_d)
      ST_SYNC: begin
        result_o.cmd_exec = 1'b1;
      end
      ST_JOG: begin
        result_o.jog_dirs          = {ys_q[15], (ys_q != 16'd0) && !ys_q[15],
                                      ps_q[15], (ps_q != 16'd0) && !ps_q[15]};
        result_o.jog_override_full = 1'b1;
      end
      ST_FOLLOW: begin
        result_o.cmd_exec         = 1'b1;
        result_o.cmd_target_pitch = 32'(tp_q);
        result_o.cmd_target_yaw   = 32'(ty_q);
      end
      default: begin
      end
    endcase
  end

  // Ages restart on a message and saturate-increment on each tick.
  always_comb begin
    op_age_d  = op_age_q;
    plc_age_d = plc_age_q;
    if (fire_i) begin
      unique case (item_i.opcode)
        OP_CMD:    op_age_d  = '0;
        OP_STATUS: plc_age_d = '0;
        OP_TICK: begin
          if (op_age_q != '1) begin
            op_age_d = op_age_q + 1'b1;
          end
          if (plc_age_q != '1) begin
            plc_age_d = plc_age_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TimeoutReset;
      mode_code_q  <= '0;
      reset_req_q  <= 1'b0;
      tp_q         <= '0;
      ty_q         <= '0;
      ps_q         <= '0;
      ys_q         <= '0;
      fault_q      <= 1'b0;
      op_age_q     <= '0;
      plc_age_q    <= '0;
      state_q      <= ST_STOP;
      prev_reset_q <= 1'b0;
    end else begin
      op_age_q  <= op_age_d;
      plc_age_q <= plc_age_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (fire_i && item_i.opcode == OP_CMD) begin
        mode_code_q <= item_i.requested_mode_code;
        reset_req_q <= item_i.reset_request;
        tp_q        <= tp_d;
        ty_q        <= ty_d;
        ps_q        <= item_i.pitch_speed_in;
        ys_q        <= item_i.yaw_speed_in;
      end
      if (fire_i && item_i.opcode == OP_STATUS) begin
        fault_q <= (item_i.plc_error_code != 16'd0);
      end
      if (tick_o) begin
        state_q      <= state_d;
        prev_reset_q <= reset_req_q;
      end
    end
  end

  // The stored state is kept for visibility; the decision does not read it.
  logic unused_state;
  assign unused_state = ^state_q;

endmodule

`default_nettype wire

// File: src/gms_out_stage.sv
// Result register of the gimbal mode supervisor with its valid flag.
// Depends on gms_pkg.
`default_nettype none

module gms_out_stage
  import gms_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// File: src/gimbal_mode_supervisor.sv
// Top level of the gimbal mode supervisor: stream ports, config port and the
// input register, core and result register. Depends on gms_pkg and gms_*.
//
// Usage:
//   The slave stream takes three kinds of item, selected by s_axis_tuser:
//   operator commands, controller status and supervisor cycle ticks. A
//   command or a status transfer only updates held data and restarts the age
//   of its link. Each tick produces exactly one result transfer on the master
//   stream with the commanded mode, execute and acknowledge flags, jog
//   directions, follow targets, the supervisor state and the link status.
//   Kind code 3 is consumed without effect.
//   A tick transfer lands in the input register; the decision logic behind
//   it loads the result register once that register is free, and the
//   result leaves from there when the receiver takes it.
//   Throughput is one item per cycle, save that a tick waits for a free
//   result register; it is set by the single decision pass between them.
//   When the receiver stalls, the pending result waits in the result
//   register; commands and status still flow, and a tick waits in the input
//   register, holding back the slave stream, until the result register
//   frees up.
//   The timeout register is written through the cfg channel, which is always ready;
//   the user is to write it only while the block is idle, which is not enforced.
//   Reset clears all held data and ages, loads the timeout with 25 ticks and
//   puts the supervisor in the stop state, which is never reported.
`default_nettype none

module gimbal_mode_supervisor
  import gms_pkg::*;
#(
  parameter int AGE_WIDTH    = GmsAgeWidth,
  parameter int TARGET_WIDTH = GmsTargetWidth
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0: requested_mode_code[2:0], reset_request, target_pitch_in[31:0],
  // target_yaw_in[31:0], pitch_speed_in[15:0], yaw_speed_in[15:0],
  // plc_error_code[15:0], zero padding.
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,
  // Fields from bit 0: opcode[1:0].
  input  wire logic [InUserWidth-1:0]  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // Fields from bit 0: cmd_mode[1:0], cmd_exec, cmd_ack, jog_dirs[3:0],
  // jog_override_full, cmd_target_pitch[31:0], cmd_target_yaw[31:0],
  // supervisor_state[2:0], operator_online, controller_online, fault_active,
  // zero padding.
  output logic [OutDataWidth-1:0]      m_axis_tdata,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [TimeoutWidth-1:0] cfg_data_i
);

  in_item_t in_item, item;
  result_t  result, result_q;
  logic     fire, tick, out_free;

  // Unpack the slave payload.
  assign in_item.opcode              = s_axis_tuser;
  assign in_item.requested_mode_code = s_axis_tdata[2:0];
  assign in_item.reset_request       = s_axis_tdata[3];
  assign in_item.target_pitch_in     = s_axis_tdata[35:4];
  assign in_item.target_yaw_in       = s_axis_tdata[67:36];
  assign in_item.pitch_speed_in      = s_axis_tdata[83:68];
  assign in_item.yaw_speed_in        = s_axis_tdata[99:84];
  assign in_item.plc_error_code      = s_axis_tdata[115:100];

  // The timeout register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  gms_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .out_free_i (out_free),
    .fire_o     (fire),
    .item_o     (item)
  );

  gms_core #(
    .AGE_WIDTH    (AGE_WIDTH),
    .TARGET_WIDTH (TARGET_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (item),
    .tick_o     (tick),
    .result_o   (result)
  );

  gms_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (tick),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result_q)
  );

  // Pack the master payload, first field in the lowest bits.
  assign m_axis_tdata = {1'b0,
                         result_q.fault_active,
                         result_q.controller_online,
                         result_q.operator_online,
                         result_q.supervisor_state,
                         result_q.cmd_target_yaw,
                         result_q.cmd_target_pitch,
                         result_q.jog_override_full,
                         result_q.jog_dirs,
                         result_q.cmd_ack,
                         result_q.cmd_exec,
                         result_q.cmd_mode};

endmodule

`default_nettype wire

// File: src/gms_checker.sv
// Port-level checks of the gimbal mode supervisor results, bound to the top.
// Depends on gms_pkg and gimbal_mode_supervisor.
`default_nettype none

module gms_port_asserts
  import gms_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata
);

  logic [2:0] st;
  assign st = m_axis_tdata[75:73];

  // A held result does not change while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Execute is set exactly in the sync and follow states.
  a_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] == (st == SUP_SYNC || st == SUP_FOLLOW)))
    else $error("execute flag does not match state");

  // Full speed override and jog directions appear only in the jog state.
  a_jog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st != SUP_JOG |-> m_axis_tdata[8:4] == 5'd0)
    else $error("jog outputs outside jog state");

  // An acknowledge resolves to ready with the fault still flagged, and error always reports idle mode.
  a_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3] || st == SUP_ERROR) |->
      (m_axis_tdata[3] ? (st == SUP_READY && m_axis_tdata[78]) : m_axis_tdata[1:0] == 2'd0))
    else $error("acknowledge or error outputs inconsistent");

  // Targets are zero outside the follow state.
  a_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st != SUP_FOLLOW |-> m_axis_tdata[72:9] == 64'd0)
    else $error("targets nonzero outside follow state");

endmodule

bind gimbal_mode_supervisor gms_port_asserts u_gms_port_asserts (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
